[rtl/tvfp_pkg.sv]
// ----------------------------------------------------------------------------
// tvfp_pkg
// Shared types and constants for the tag=value field parser.
// ----------------------------------------------------------------------------
package tvfp_pkg;

  localparam int DEF_MAX_TAG_LEN    = 32;
  localparam int DEF_MAX_LEN_DIGITS = 8;

  // 8 decimal digits fit in 27 bits
  localparam int RAW_LEN_W = 27;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [7:0] DELIM_RESET = 8'h01;
  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_EQ     = 8'h3D;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;

  // register index, taken from paddr[2]
  localparam logic REG_DELIMITER = 1'b0;

  typedef enum logic [3:0] {
    ROLE_TAG     = 4'd0,
    ROLE_RMARK   = 4'd1,
    ROLE_EQUALS  = 4'd2,
    ROLE_TEXT    = 4'd3,
    ROLE_DIGIT   = 4'd4,
    ROLE_REPEAT  = 4'd5,
    ROLE_RAW     = 4'd6,
    ROLE_DELIM   = 4'd7,
    ROLE_IGNORED = 4'd8
  } role_t;

endpackage

[rtl/tvfp_in_if.sv]
// ----------------------------------------------------------------------------
// tvfp_in_if
// Message byte channel: one byte with its last flag per transaction.
// ----------------------------------------------------------------------------
interface tvfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/tvfp_out_if.sv]
// ----------------------------------------------------------------------------
// tvfp_out_if
// Result channel: the byte passed through with its role and flags.
// ----------------------------------------------------------------------------
interface tvfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] role;
  logic       raw_field;
  logic       field_end;
  logic       error;
  logic       message_done;
  logic       tail_dropped;

  modport source (output valid, output out_byte, output role, output raw_field,
                  output field_end, output error, output message_done,
                  output tail_dropped, input ready);
  modport sink   (input valid, input out_byte, input role, input raw_field,
                  input field_end, input error, input message_done,
                  input tail_dropped, output ready);
endinterface

[rtl/tag_value_field_parser.sv]
// ----------------------------------------------------------------------------
// tag_value_field_parser
// Labels each byte of a tag=value message with its role in the field.
//
//   channel  direction  transfer               payload
//   msg      in         valid && ready         in_byte, in_last
//   res      out        valid && ready         out_byte, role, flags
//   apb      in         psel, penable, pwrite  delimiter register at 0x0
//
// one byte per cycle sustained while res.ready is high, result valid the cycle after accept
// the tag store read is issued ahead of the compare, so repeated tag bytes compare
// at full rate with no interlock
// synchronous reset clears the parse state; the tag store is not cleared
// msg.ready drops only when the output register is full and res.ready is low
// ----------------------------------------------------------------------------
module tag_value_field_parser #(
  parameter int MAX_TAG_LEN    = tvfp_pkg::DEF_MAX_TAG_LEN,
  parameter int MAX_LEN_DIGITS = tvfp_pkg::DEF_MAX_LEN_DIGITS
) (
  input  logic                            clk,
  input  logic                            rst,
  tvfp_in_if.sink                         msg,
  tvfp_out_if.source                      res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tvfp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tvfp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tvfp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tvfp_pkg::*;

  localparam int AW = $clog2(MAX_TAG_LEN);

  logic [7:0]    delimiter;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  tvfp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .delimiter (delimiter)
  );

  tvfp_tag_mem #(
    .DEPTH (MAX_TAG_LEN)
  ) u_tag_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tvfp_core #(
    .MAX_TAG_LEN    (MAX_TAG_LEN),
    .MAX_LEN_DIGITS (MAX_LEN_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .delimiter (delimiter),
    .msg       (msg),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

[rtl/tvfp_cfg.sv]
// ----------------------------------------------------------------------------
// tvfp_cfg
// APB register slave holding the field delimiter byte.
// ----------------------------------------------------------------------------
module tvfp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tvfp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tvfp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tvfp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [7:0]                       delimiter
);
  import tvfp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DELIMITER);

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (wr_en) begin
      delimiter <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DELIMITER) begin
      prdata = {{(APB_DATA_W-8){1'b0}}, delimiter};
    end
  end

endmodule

[rtl/tvfp_tag_mem.sv]
// ----------------------------------------------------------------------------
// tvfp_tag_mem
// Tag byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tvfp_tag_mem #(
  parameter int DEPTH = tvfp_pkg::DEF_MAX_TAG_LEN
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tvfp_core.sv]
// ----------------------------------------------------------------------------
// tvfp_core
// Per-byte parse state machine with output register. Reads the tag store
// ahead of each compare so the repeated tag byte is on hand when it arrives.
// ----------------------------------------------------------------------------
module tvfp_core #(
  parameter int MAX_TAG_LEN    = tvfp_pkg::DEF_MAX_TAG_LEN,
  parameter int MAX_LEN_DIGITS = tvfp_pkg::DEF_MAX_LEN_DIGITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [7:0]                     delimiter,
  tvfp_in_if.sink                        msg,
  tvfp_out_if.source                     res,
  output logic                           mem_we,
  output logic [$clog2(MAX_TAG_LEN)-1:0] mem_waddr,
  output logic [7:0]                     mem_wdata,
  output logic [$clog2(MAX_TAG_LEN)-1:0] mem_raddr,
  input  logic [7:0]                     mem_rdata
);
  import tvfp_pkg::*;

  localparam int AW  = $clog2(MAX_TAG_LEN);
  localparam int TLW = $clog2(MAX_TAG_LEN + 1);
  localparam int DCW = $clog2(MAX_LEN_DIGITS + 1);

  typedef enum logic [2:0] {
    TAG_START,
    TEXT_TAG,
    RAW_TAG,
    TEXT_VALUE,
    LENGTH,
    REPEAT,
    RAW_VALUE,
    RAW_CLOSE
  } mode_t;

  mode_t                mode, mode_next;
  logic [TLW-1:0]       tag_length, tag_length_next;
  logic [TLW-1:0]       compare_index, compare_index_next;
  logic [DCW-1:0]       digit_count, digit_count_next;
  logic [RAW_LEN_W-1:0] raw_length, raw_length_next;
  logic [RAW_LEN_W-1:0] raw_remaining, raw_remaining_next;
  logic                 error_latched, error_latched_next;

  logic                 accept;
  logic [7:0]           b;
  logic                 is_delim;
  logic                 is_digit;
  logic                 tag_full;
  logic                 bad;
  logic                 dropped;
  role_t                role_c;
  logic                 raw_c;
  logic                 fend_c;
  logic [RAW_LEN_W-1:0] rem_dec;

  logic                 out_valid;
  logic [7:0]           out_byte_q;
  role_t                out_role_q;
  logic                 out_raw_q;
  logic                 out_fend_q;
  logic                 out_err_q;
  logic                 out_done_q;
  logic                 out_drop_q;

  assign msg.ready = !out_valid || res.ready;
  assign accept    = msg.valid && msg.ready;

  assign b        = msg.in_byte;
  assign is_delim = (b == delimiter);
  assign is_digit = (b >= CHAR_0) && (b <= CHAR_9);
  assign tag_full = (tag_length >= TLW'(MAX_TAG_LEN));

  assign mem_waddr = tag_length[AW-1:0];
  assign mem_wdata = b;

  always_comb begin
    mode_next          = mode;
    tag_length_next    = tag_length;
    compare_index_next = compare_index;
    digit_count_next   = digit_count;
    raw_length_next    = raw_length;
    raw_remaining_next = raw_remaining;
    error_latched_next = error_latched;
    role_c             = ROLE_IGNORED;
    raw_c              = 1'b0;
    fend_c             = 1'b0;
    bad                = 1'b0;
    dropped            = 1'b0;
    mem_we             = 1'b0;
    rem_dec            = raw_remaining;

    if (!error_latched) begin
      unique case (mode)
        TAG_START: begin
          priority if (b == CHAR_EQ) begin
            role_c    = ROLE_EQUALS;
            mode_next = TEXT_VALUE;
          end else if (is_delim) begin
            bad = 1'b1;
          end else if (b == CHAR_R) begin
            role_c          = ROLE_RMARK;
            raw_c           = 1'b1;
            tag_length_next = '0;
            mode_next       = RAW_TAG;
          end else begin
            role_c          = ROLE_TAG;
            tag_length_next = TLW'(1);
            mode_next       = TEXT_TAG;
          end
        end
        TEXT_TAG: begin
          priority if (b == CHAR_EQ) begin
            role_c    = ROLE_EQUALS;
            mode_next = TEXT_VALUE;
          end else if (is_delim || tag_full) begin
            bad = 1'b1;
          end else begin
            role_c          = ROLE_TAG;
            tag_length_next = tag_length + TLW'(1);
          end
        end
        RAW_TAG: begin
          raw_c = 1'b1;
          priority if (b == CHAR_EQ) begin
            role_c           = ROLE_EQUALS;
            digit_count_next = '0;
            raw_length_next  = '0;
            mode_next        = LENGTH;
          end else if (is_delim || tag_full) begin
            bad = 1'b1;
          end else begin
            role_c          = ROLE_TAG;
            mem_we          = accept;
            tag_length_next = tag_length + TLW'(1);
          end
        end
        TEXT_VALUE: begin
          if (is_delim) begin
            role_c    = ROLE_DELIM;
            fend_c    = 1'b1;
            mode_next = TAG_START;
          end else begin
            role_c = ROLE_TEXT;
          end
        end
        LENGTH: begin
          raw_c = 1'b1;
          priority if (is_delim) begin
            role_c             = ROLE_DELIM;
            raw_remaining_next = raw_length;
            compare_index_next = '0;
            mode_next          = REPEAT;
          end else if (digit_count >= DCW'(MAX_LEN_DIGITS) || !is_digit) begin
            bad = 1'b1;
          end else begin
            role_c           = ROLE_DIGIT;
            digit_count_next = digit_count + DCW'(1);
            // times ten as two shifted adds
            raw_length_next  = (raw_length << 3) + (raw_length << 1)
                             + RAW_LEN_W'(b[3:0]);
          end
        end
        REPEAT: begin
          raw_c = 1'b1;
          priority if (compare_index < tag_length) begin
            if (b == mem_rdata) begin
              role_c             = ROLE_REPEAT;
              compare_index_next = compare_index + TLW'(1);
            end else begin
              bad = 1'b1;
            end
          end else if (b == CHAR_EQ) begin
            role_c    = ROLE_EQUALS;
            mode_next = (raw_length == '0) ? RAW_CLOSE : RAW_VALUE;
          end else begin
            bad = 1'b1;
          end
        end
        RAW_VALUE: begin
          raw_c  = 1'b1;
          role_c = ROLE_RAW;
          if (raw_remaining != '0) begin
            rem_dec = raw_remaining - RAW_LEN_W'(1);
          end
          raw_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            mode_next = RAW_CLOSE;
          end
        end
        RAW_CLOSE: begin
          raw_c = 1'b1;
          if (is_delim) begin
            role_c    = ROLE_DELIM;
            fend_c    = 1'b1;
            mode_next = TAG_START;
          end else begin
            bad = 1'b1;
          end
        end
      endcase

      priority if (bad) begin
        error_latched_next = 1'b1;
        role_c             = ROLE_IGNORED;
        raw_c              = 1'b0;
        fend_c             = 1'b0;
      end else if (msg.in_last) begin
        // a field cut off in its tag or text is dropped, one cut off elsewhere is an error
        if (mode_next == TEXT_TAG || mode_next == RAW_TAG || mode_next == TEXT_VALUE) begin
          dropped = 1'b1;
        end else if (mode_next != TAG_START) begin
          error_latched_next = 1'b1;
        end
      end else begin
      end
    end

    // results of this byte are captured above; end of message clears the parse
    if (msg.in_last) begin
      mode_next          = TAG_START;
      tag_length_next    = '0;
      compare_index_next = '0;
      digit_count_next   = '0;
      raw_length_next    = '0;
      raw_remaining_next = '0;
    end

    // keep the read one step ahead of the next compared byte
    mem_raddr = accept ? compare_index_next[AW-1:0] : compare_index[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= TAG_START;
      tag_length    <= '0;
      compare_index <= '0;
      digit_count   <= '0;
      raw_length    <= '0;
      raw_remaining <= '0;
      error_latched <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        mode          <= mode_next;
        tag_length    <= tag_length_next;
        compare_index <= compare_index_next;
        digit_count   <= digit_count_next;
        raw_length    <= raw_length_next;
        raw_remaining <= raw_remaining_next;
        error_latched <= error_latched_next && !msg.in_last;
        out_valid     <= 1'b1;
        out_byte_q    <= b;
        out_role_q    <= role_c;
        out_raw_q     <= raw_c;
        out_fend_q    <= fend_c;
        out_err_q     <= error_latched_next;
        out_done_q    <= msg.in_last;
        out_drop_q    <= dropped && !error_latched_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid        = out_valid;
  assign res.out_byte     = out_byte_q;
  assign res.role         = out_role_q;
  assign res.raw_field    = out_raw_q;
  assign res.field_end    = out_fend_q;
  assign res.error        = out_err_q;
  assign res.message_done = out_done_q;
  assign res.tail_dropped = out_drop_q;

endmodule
